// File: src/double_hash_key_value_table_unit_assert.svh
// Assertion macros used by the checker file of the hash table unit.
`ifndef DOUBLE_HASH_KEY_VALUE_TABLE_UNIT_ASSERT_SVH
`define DOUBLE_HASH_KEY_VALUE_TABLE_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DHKV_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DHKV_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/dhkv_pkg.sv
// Types and constants of the double-hash key/value table unit.
`timescale 1ns / 1ps
package dhkv_pkg;

    localparam int FUNC_W    = 2;
    localparam int KEY_W     = 64;
    localparam int VALUE_W   = 32;
    localparam int STATUS_W  = 2;
    localparam int SLOT_W    = 10;
    localparam int COUNT_W   = 11;
    localparam int SIZE_W    = 11;

    localparam int S_TDATA_W = 104;
    localparam int M_TDATA_W = 56;

    // Output field offsets inside m_tdata
    localparam int M_STATUS_LO = 0;
    localparam int M_VALUE_LO  = M_STATUS_LO + STATUS_W;
    localparam int M_SLOT_LO   = M_VALUE_LO + VALUE_W;
    localparam int M_COUNT_LO  = M_SLOT_LO + SLOT_W;

    localparam logic [SIZE_W-1:0] TABLE_SIZE_RESET = 11'd1021;

    localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_DELETE = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_BAD    = 2'd3;

    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_MISSING = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_UNUSED  = 2'd3;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_SETUP,
        ST_READ,
        ST_CHECK,
        ST_OUT
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic clear_step;
        logic capture;
        logic div_step;
        logic setup;
        logic read;
        logic advance;
        logic resolve;
        logic load_out;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic clear_last;
        logic func_bad;
        logic div_last;
        logic chk_done;
        logic out_free;
    } sts_t;

endpackage

// File: src/dhkv_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module dhkv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: src/dhkv_ctrl.sv
// Controller state machine of the hash table unit.
`timescale 1ns / 1ps
module dhkv_ctrl import dhkv_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    // State register, clearing pass first after reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (sts.clear_last) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_tvalid) state_next = sts.func_bad ? ST_OUT : ST_DIV;
            end
            ST_DIV: begin
                if (sts.div_last) state_next = ST_SETUP;
            end
            ST_SETUP: state_next = ST_READ;
            ST_READ:  state_next = ST_CHECK;
            ST_CHECK: begin
                state_next = sts.chk_done ? ST_OUT : ST_READ;
            end
            ST_OUT: begin
                if (sts.out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Commands
    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            ST_CLEAR: cmd.clear_step = 1'b1;
            ST_IDLE: begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
            end
            ST_DIV:   cmd.div_step = 1'b1;
            ST_SETUP: cmd.setup = 1'b1;
            ST_READ:  cmd.read = 1'b1;
            ST_CHECK: begin
                cmd.advance = !sts.chk_done;
                cmd.resolve = sts.chk_done;
            end
            ST_OUT:   cmd.load_out = sts.out_free;
            default:  cmd = '0;
        endcase
    end

endmodule

// File: src/dhkv_datapath.sv
// Datapath: size register, iterative modulo, probe walk, slot store and result register.
`timescale 1ns / 1ps
module dhkv_datapath import dhkv_pkg::*; #(
    parameter int CAPACITY   = 1024,
    parameter int KEY_BITS   = 64,
    parameter int VALUE_BITS = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [SIZE_W-1:0]    cfg_wdata,
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    input  cmd_t                 cmd,
    output sts_t                 sts
);

    localparam int AW = $clog2(CAPACITY);
    localparam int NW = $clog2(CAPACITY + 1);
    localparam int DW = $clog2(KEY_BITS);
    localparam int WW = 1 + KEY_BITS + VALUE_BITS;

    logic [SIZE_W-1:0]     table_size_reg;
    logic [AW-1:0]         clr_addr_reg;
    logic [FUNC_W-1:0]     func_reg;
    logic [KEY_BITS-1:0]   key_reg;
    logic [VALUE_BITS-1:0] val_reg;
    logic [KEY_BITS-1:0]   shift_reg;
    logic [DW-1:0]         div_cnt_reg;
    logic [NW-1:0]         rem_reg;
    logic [NW-1:0]         pos_reg;
    logic [NW-1:0]         step_reg;
    logic [NW-1:0]         probe_cnt_reg;
    logic [NW-1:0]         count_reg;
    logic [STATUS_W-1:0]   res_status_reg;
    logic [VALUE_W-1:0]    res_val_reg;
    logic [SLOT_W-1:0]     res_slot_reg;
    logic                  out_valid_reg;
    logic [M_TDATA_W-1:0]  out_data_reg;

    logic [NW-1:0]         n_eff;
    logic [NW:0]           rem_sh;
    logic [NW-1:0]         rem_next;
    logic [NW:0]           pos_sum;
    logic [NW-1:0]         pos_next;
    logic [FUNC_W-1:0]     s_func;
    logic [WW-1:0]         rd_word;
    logic                  rd_valid;
    logic [KEY_BITS-1:0]   rd_key;
    logic [VALUE_BITS-1:0] rd_val;
    logic                  hit;
    logic                  empty;
    logic                  probe_last;
    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [WW-1:0]         ram_wdata;

    assign s_func = s_tdata[FUNC_W-1:0];

    // Size register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            table_size_reg <= TABLE_SIZE_RESET;
        end else if (cfg_we) begin
            table_size_reg <= cfg_wdata;
        end
    end

    // Clamp size into 1..CAPACITY
    always_comb begin
        if (table_size_reg == '0) begin
            n_eff = NW'(1);
        end else if (32'(table_size_reg) > CAPACITY) begin
            n_eff = NW'(CAPACITY);
        end else begin
            n_eff = NW'(table_size_reg);
        end
    end

    // Restoring modulo step, one key bit per cycle
    assign rem_sh   = {rem_reg, shift_reg[KEY_BITS-1]};
    assign rem_next = (rem_sh >= {1'b0, n_eff}) ? NW'(rem_sh - {1'b0, n_eff}) : NW'(rem_sh);

    // Next probe slot, wrapped into the table
    assign pos_sum  = {1'b0, pos_reg} + {1'b0, step_reg};
    assign pos_next = (pos_sum >= {1'b0, n_eff}) ? NW'(pos_sum - {1'b0, n_eff}) : NW'(pos_sum);

    // Slot word fields
    assign rd_valid   = rd_word[WW-1];
    assign rd_key     = rd_word[VALUE_BITS +: KEY_BITS];
    assign rd_val     = rd_word[VALUE_BITS-1:0];
    assign empty      = !rd_valid;
    assign hit        = rd_valid && (rd_key == key_reg);
    assign probe_last = (probe_cnt_reg == NW'(n_eff - NW'(1)));

    // Clearing pass address
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg <= '0;
        end else if (cmd.clear_step) begin
            clr_addr_reg <= clr_addr_reg + AW'(1);
        end
    end

    // Operand capture, modulo and probe registers
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            func_reg    <= s_func;
            key_reg     <= KEY_BITS'(s_tdata[FUNC_W +: KEY_W]);
            shift_reg   <= KEY_BITS'(s_tdata[FUNC_W +: KEY_W]);
            val_reg     <= VALUE_BITS'(s_tdata[FUNC_W + KEY_W +: VALUE_W]);
            rem_reg     <= '0;
            div_cnt_reg <= '0;
        end else if (cmd.div_step) begin
            rem_reg     <= rem_next;
            shift_reg   <= shift_reg << 1;
            div_cnt_reg <= div_cnt_reg + DW'(1);
        end
        if (cmd.setup) begin
            pos_reg       <= rem_reg;
            step_reg      <= n_eff - rem_reg;
            probe_cnt_reg <= '0;
        end else if (cmd.advance) begin
            pos_reg       <= pos_next;
            probe_cnt_reg <= probe_cnt_reg + NW'(1);
        end
    end

    // Store write: clearing pass or the resolved probe
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = AW'(pos_reg);
        ram_wdata = {1'b1, key_reg, val_reg};
        if (cmd.clear_step) begin
            ram_we    = 1'b1;
            ram_waddr = clr_addr_reg;
            ram_wdata = '0;
        end else if (cmd.resolve) begin
            if (func_reg == FUNC_INSERT) begin
                ram_we = hit || empty;
            end else if (func_reg == FUNC_DELETE) begin
                ram_we    = hit;
                ram_wdata = {1'b0, rd_key, rd_val};
            end
        end
    end

    dhkv_ram #(
        .WIDTH (WW),
        .DEPTH (CAPACITY)
    ) u_slot_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.read),
        .raddr (AW'(pos_reg)),
        .rdata (rd_word)
    );

    // Occupied count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (cmd.resolve) begin
            if (func_reg == FUNC_INSERT && !hit && empty) begin
                count_reg <= count_reg + NW'(1);
            end else if (func_reg == FUNC_DELETE && hit && count_reg != '0) begin
                count_reg <= count_reg - NW'(1);
            end
        end
    end

    // Result fields: defaults at capture, outcome at resolve
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            res_status_reg <= STATUS_MISSING;
            res_val_reg    <= '0;
            res_slot_reg   <= '0;
        end else if (cmd.resolve) begin
            case (func_reg)
                FUNC_LOOKUP: begin
                    if (hit) begin
                        res_status_reg <= STATUS_OK;
                        res_val_reg    <= VALUE_W'(rd_val);
                        res_slot_reg   <= SLOT_W'(pos_reg);
                    end
                end
                FUNC_INSERT: begin
                    if (hit || empty) begin
                        res_status_reg <= STATUS_OK;
                        res_slot_reg   <= SLOT_W'(pos_reg);
                    end else begin
                        res_status_reg <= STATUS_FULL;
                    end
                end
                FUNC_DELETE: begin
                    if (hit) begin
                        res_status_reg <= STATUS_OK;
                        res_slot_reg   <= SLOT_W'(pos_reg);
                    end
                end
                default: res_status_reg <= STATUS_MISSING;
            endcase
        end
    end

    // Output register, loaded only when empty or being drained
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_data_reg <= {1'b0, COUNT_W'(count_reg), res_slot_reg, res_val_reg,
                             res_status_reg};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // Status to controller
    assign sts.clear_last = (clr_addr_reg == AW'(CAPACITY - 1));
    assign sts.func_bad   = (s_func == FUNC_BAD);
    assign sts.div_last   = (div_cnt_reg == DW'(KEY_BITS - 1));
    assign sts.chk_done   = empty || hit || probe_last;
    assign sts.out_free   = !out_valid_reg || m_tready;

endmodule

// File: src/double_hash_key_value_table_unit.sv
// Top level of the double-hash open-addressed key/value table unit.
//
//   channel   direction  payload (low bit first)
//   s_*       in         func[1:0], key[65:2], value[97:66], zero fill to 104
//   m_*       out        status[1:0], read_value[33:2], slot_index[43:34],
//                        entry_count[54:44], zero fill to 56
//   cfg_*     in         table_size[10:0], written whenever cfg_we is high
//
// One transaction at a time, in order: an accept step, the bit-serial modulo over
// all KEY_BITS key bits, a setup step, then per probe a slot RAM read and a compare,
// and a final step that loads the result; the registered slot RAM read splits each probe in two.
// An unknown func skips straight to the result.
// After reset a clearing pass empties every slot; s_tready
// stays low during it. A result waiting on m_tready holds only the final load.
`timescale 1ns / 1ps
module double_hash_key_value_table_unit import dhkv_pkg::*; #(
    parameter int CAPACITY   = 1024,
    parameter int KEY_BITS   = 64,
    parameter int VALUE_BITS = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [SIZE_W-1:0]    cfg_wdata,   // table_size
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,     // func, key, value
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata      // status, read_value, slot_index, entry_count
);

    cmd_t cmd;
    sts_t sts;

    dhkv_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    dhkv_datapath #(
        .CAPACITY   (CAPACITY),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

// File: src/dhkv_checker.sv
// Port-level checker of the hash table unit and its bind.
`timescale 1ns / 1ps
`include "double_hash_key_value_table_unit_assert.svh"
module dhkv_checker import dhkv_pkg::*; (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    logic [STATUS_W-1:0] status;

    assign status = m_tdata[M_STATUS_LO +: STATUS_W];

    // A stalled result stays and holds its payload
    `DHKV_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result dropped or changed while stalled")

    // Status is never the unused code
    `DHKV_ASSERT_NOW(a_status_code, aclk, aresetn, m_tvalid, status != STATUS_UNUSED, "unused status code")

    // Only a success may carry a slot
    `DHKV_ASSERT_NOW(a_slot_zero, aclk, aresetn, m_tvalid && status != STATUS_OK, m_tdata[M_SLOT_LO +: SLOT_W] == '0, "slot set on failure")

    // Only a success may carry data
    `DHKV_ASSERT_NOW(a_value_zero, aclk, aresetn, m_tvalid && status != STATUS_OK, m_tdata[M_VALUE_LO +: VALUE_W] == '0, "read value set on failure")

endmodule

bind double_hash_key_value_table_unit dhkv_checker u_dhkv_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// File: tb/sv/tb_double_hash_key_value_table_unit.sv
// Self-checking testbench of the double-hash key/value table unit.
`timescale 1ns / 1ps
module tb_double_hash_key_value_table_unit;
    import dhkv_pkg::*;

    localparam int CAP = 1024;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [SIZE_W-1:0]    cfg_wdata = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    double_hash_key_value_table_unit dut (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    typedef struct packed {
        logic [COUNT_W-1:0]  count;
        logic [SLOT_W-1:0]   slot;
        logic [VALUE_W-1:0]  rdval;
        logic [STATUS_W-1:0] status;
    } reply_t;

    typedef struct {
        logic [FUNC_W-1:0]  func;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
        bit                 typed;
        reply_t             want;
    } row_t;

    // Shadow copy of the table
    logic               shadow_valid [CAP];
    logic [KEY_W-1:0]   shadow_key   [CAP];
    logic [VALUE_W-1:0] shadow_value [CAP];
    int unsigned        shadow_count;
    int unsigned        shadow_size;

    reply_t      pending_replies[$];
    int unsigned error_count = 0;
    int unsigned sent = 0, received = 0, full_seen = 0, hits_seen = 0;

    // Walk the probe chain, update the shadow and return the reply
    function automatic reply_t table_apply(logic [FUNC_W-1:0] func,
                                           logic [KEY_W-1:0] key,
                                           logic [VALUE_W-1:0] value);
        reply_t r;
        int unsigned n, pos, step, hit, empty_at;
        bit found, saw_empty;
        r = '0;
        r.status = STATUS_MISSING;
        found = 0;
        saw_empty = 0;
        hit = 0;
        empty_at = 0;
        n = shadow_size;
        if (n == 0) n = 1;
        if (n > CAP) n = CAP;
        if (func != FUNC_BAD) begin
            pos = 32'(key % 64'(n));
            step = n - pos;
            for (int unsigned i = 0; i < n; i++) begin
                if (!shadow_valid[pos]) begin
                    saw_empty = 1;
                    empty_at = pos;
                    break;
                end
                if (shadow_key[pos] == key) begin
                    found = 1;
                    hit = pos;
                    break;
                end
                pos += step;
                if (pos >= n) pos -= n;
            end
            case (func)
                FUNC_LOOKUP: begin
                    if (found) begin
                        r.status = STATUS_OK;
                        r.rdval = shadow_value[hit];
                        r.slot = SLOT_W'(hit);
                    end
                end
                FUNC_INSERT: begin
                    if (found) begin
                        shadow_value[hit] = value;
                        r.status = STATUS_OK;
                        r.slot = SLOT_W'(hit);
                    end else if (saw_empty) begin
                        shadow_valid[empty_at] = 1'b1;
                        shadow_key[empty_at] = key;
                        shadow_value[empty_at] = value;
                        shadow_count++;
                        r.status = STATUS_OK;
                        r.slot = SLOT_W'(empty_at);
                    end else begin
                        r.status = STATUS_FULL;
                    end
                end
                default: begin
                    if (found) begin
                        shadow_valid[hit] = 1'b0;
                        if (shadow_count > 0) shadow_count--;
                        r.status = STATUS_OK;
                        r.slot = SLOT_W'(hit);
                    end
                end
            endcase
        end
        r.count = COUNT_W'(shadow_count);
        return r;
    endfunction

    // Send one transaction after a random gap; valid stays high across a zero gap
    task automatic send_op(logic [FUNC_W-1:0] func, logic [KEY_W-1:0] key,
                           logic [VALUE_W-1:0] value, bit typed, reply_t want);
        reply_t r;
        int unsigned gap;
        gap = $urandom_range(0, 16);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        r = table_apply(func, key, value);
        if (typed && r !== want) begin
            $display("%0t table row mismatch: expected %h actual %h", $time, want, r);
            error_count++;
        end
        pending_replies.push_back(r);
        s_tdata <= {6'd0, value, key, func};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        sent++;
        @(negedge aclk);
    endtask

    // Drop valid, wait for all replies and the block's tail latency, then write size
    task automatic set_size(int unsigned sz);
        s_tvalid <= 1'b0;
        while (pending_replies.size() != 0) @(negedge aclk);
        repeat (80) @(negedge aclk);
        cfg_wdata <= SIZE_W'(sz);
        cfg_we <= 1'b1;
        @(negedge aclk);
        cfg_we <= 1'b0;
        shadow_size = sz;
    endtask

    // Draw a key, mostly in 0..span so homes crowd together and chains get long; one in ten is fully random
    function automatic logic [KEY_W-1:0] pick_key(int unsigned span);
        logic [KEY_W-1:0] k;
        if ($urandom_range(0, 9) == 0) k = {$urandom, $urandom};
        else k = KEY_W'($urandom_range(0, span));
        return k;
    endfunction

    // Receive side: random stall, check each transaction
    initial begin
        reply_t got, want;
        int unsigned gap;
        forever begin
            @(negedge aclk);
            gap = $urandom_range(0, 16);
            if (gap != 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            got = m_tdata[$bits(reply_t)-1:0];
            received++;
            if (pending_replies.size() == 0) begin
                $display("%0t unexpected result: expected none actual %h", $time, got);
                error_count++;
            end else begin
                want = pending_replies.pop_front();
                if (got.status !== want.status) begin
                    $display("%0t status: expected %0d actual %0d",
                             $time, want.status, got.status);
                    error_count++;
                end
                if (got.rdval !== want.rdval) begin
                    $display("%0t read_value: expected %h actual %h",
                             $time, want.rdval, got.rdval);
                    error_count++;
                end
                if (got.slot !== want.slot) begin
                    $display("%0t slot_index: expected %0d actual %0d",
                             $time, want.slot, got.slot);
                    error_count++;
                end
                if (got.count !== want.count) begin
                    $display("%0t entry_count: expected %0d actual %0d",
                             $time, want.count, got.count);
                    error_count++;
                end
                if (want.status == STATUS_FULL) full_seen++;
                if (want.status == STATUS_OK && want.rdval != 0) hits_seen++;
            end
        end
    end

    // Stimulus
    initial begin
        row_t rows[$];
        row_t rw;
        int unsigned sizes[6] = '{2, 3, 7, 31, 1021, 1024};
        int unsigned sz, span;
        logic [FUNC_W-1:0] f;
        for (int i = 0; i < CAP; i++) begin
            shadow_valid[i] = 1'b0;
            shadow_key[i] = '0;
            shadow_value[i] = '0;
        end
        shadow_count = 0;
        shadow_size = TABLE_SIZE_RESET;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed table at reset size; typed rows follow from an empty table
        rows.push_back('{FUNC_LOOKUP, 64'd5, 32'd0, 1,
                         '{11'd0, 10'd0, 32'd0, STATUS_MISSING}});
        rows.push_back('{FUNC_DELETE, 64'd5, 32'd0, 1,
                         '{11'd0, 10'd0, 32'd0, STATUS_MISSING}});
        rows.push_back('{FUNC_BAD, '1, '1, 1, '{11'd0, 10'd0, 32'd0, STATUS_MISSING}});
        rows.push_back('{FUNC_INSERT, 64'd0, '1, 1,
                         '{11'd1, 10'd0, 32'd0, STATUS_OK}});
        rows.push_back('{FUNC_LOOKUP, 64'd0, 32'd0, 1,
                         '{11'd1, 10'd0, '1, STATUS_OK}});
        rows.push_back('{FUNC_INSERT, '1, 32'h1234_5678, 0, '0});
        rows.push_back('{FUNC_LOOKUP, '1, 32'd0, 0, '0});
        rows.push_back('{FUNC_INSERT, 64'd1021, 32'd7, 0, '0});
        rows.push_back('{FUNC_INSERT, 64'd2042, 32'd8, 0, '0});
        rows.push_back('{FUNC_INSERT, 64'd1021, 32'd9, 0, '0});
        rows.push_back('{FUNC_DELETE, 64'd1021, 32'd0, 0, '0});
        rows.push_back('{FUNC_LOOKUP, 64'd2042, 32'd0, 0, '0});
        rows.push_back('{FUNC_INSERT, 64'd1022, 32'd0, 0, '0});
        rows.push_back('{FUNC_INSERT, 64'd2043, 32'hAAAA_5555, 0, '0});
        rows.push_back('{FUNC_LOOKUP, 64'd2043, 32'd0, 0, '0});
        rows.push_back('{FUNC_BAD, 64'd1022, 32'd0, 0, '0});
        foreach (rows[i]) begin
            rw = rows[i];
            send_op(rw.func, rw.key, rw.value, rw.typed, rw.want);
        end

        // Shrink to two slots: full table, and entries stranded above n
        set_size(2);
        send_op(FUNC_INSERT, 64'd4, 32'd1, 0, '0);
        send_op(FUNC_INSERT, 64'd6, 32'd2, 0, '0);
        send_op(FUNC_INSERT, 64'd8, 32'd3, 0, '0);
        set_size(0);
        send_op(FUNC_INSERT, 64'd9, 32'd4, 0, '0);
        send_op(FUNC_LOOKUP, 64'd9, 32'd0, 0, '0);
        set_size(2047);
        send_op(FUNC_LOOKUP, 64'd1022, 32'd0, 0, '0);

        // Random phases over several sizes
        for (int ph = 0; ph < 12; ph++) begin
            sz = sizes[$urandom_range(0, 5)];
            if (ph == 11) sz = 1024;
            set_size(sz);
            span = (sz < 64) ? 3 * sz : 96;
            repeat (95) begin
                case ($urandom_range(0, 19))
                    0:              f = FUNC_BAD;
                    1, 2, 3, 4:     f = FUNC_DELETE;
                    5, 6, 7, 8, 9:  f = FUNC_LOOKUP;
                    default:        f = FUNC_INSERT;
                endcase
                send_op(f, pick_key(span), $urandom, 0, '0);
            end
        end
        s_tvalid <= 1'b0;
        while (pending_replies.size() != 0) @(negedge aclk);
        repeat (200) @(negedge aclk);
        $display("Sent %0d operations, checked %0d results (%0d full, %0d value hits).",
                 sent, received, full_seen, hits_seen);
        if (error_count == 0 && pending_replies.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #400ms;
        $display("DONE: errors detected");
        $finish;
    end
endmodule

// File: filelist.f
+incdir+src
src/dhkv_pkg.sv
src/dhkv_ram.sv
src/dhkv_ctrl.sv
src/dhkv_datapath.sv
src/double_hash_key_value_table_unit.sv
src/dhkv_checker.sv
tb/sv/tb_double_hash_key_value_table_unit.sv
